[sv/trs_pkg.sv]
// ----------------------------------------------------------------------------
// trs_pkg
// Shared types and constants of the tagged record store: request kinds,
// controller states, controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package trs_pkg;

  localparam int unsigned BufSizeDef = 1024;

  localparam int unsigned KindW   = 3;
  localparam int unsigned SizeW   = 8;
  localparam int unsigned TagW    = 8;
  localparam int unsigned NthW    = 9;
  localparam int unsigned CapW    = 11;
  localparam int unsigned OffW    = 10;
  localparam int unsigned CountW  = 10;
  localparam int unsigned PosW    = 12;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 56;

  localparam logic [TagW-1:0]   TagAny     = 8'hFF;
  localparam int unsigned       HdrBytes   = 2;
  localparam logic [SizeW-1:0]  MaxPayload = 8'd253;
  localparam logic [CapW-1:0]   CapReset   = 11'd1024;
  localparam logic [CountW-1:0] CountMax   = 10'd1023;

  typedef enum logic [KindW-1:0] {
    KindAdd    = 3'd0,
    KindWipe   = 3'd1,
    KindRewind = 3'd2,
    KindPeek   = 3'd3,
    KindNext   = 3'd4,
    KindNth    = 3'd5
  } trs_kind_e;

  typedef enum logic [2:0] {
    StIdle,
    StStart,
    StCheck,
    StEval,
    StEmit
  } trs_state_e;

  typedef struct packed {
    logic load_req;
    logic start;
    logic eval;
    logic emit;
  } trs_cmd_t;

  typedef struct packed {
    logic search;
    logic more;
    logic hit;
    logic out_free;
  } trs_sts_t;

endpackage

[sv/trs_ctrl.sv]
// ----------------------------------------------------------------------------
// trs_ctrl
// Request sequencer: accepts a request, runs the immediate update or the
// header walk one record at a time, and hands the result to the output stage.
// ----------------------------------------------------------------------------
module trs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  trs_pkg::trs_sts_t sts_i,
  output trs_pkg::trs_cmd_t cmd_o
);

  trs_pkg::trs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= trs_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      trs_pkg::StIdle: begin
        if (in_valid_i) state_d = trs_pkg::StStart;
      end
      trs_pkg::StStart: begin
        state_d = sts_i.search ? trs_pkg::StCheck : trs_pkg::StEmit;
      end
      trs_pkg::StCheck: begin
        state_d = sts_i.more ? trs_pkg::StEval : trs_pkg::StEmit;
      end
      trs_pkg::StEval: begin
        state_d = sts_i.hit ? trs_pkg::StEmit : trs_pkg::StCheck;
      end
      trs_pkg::StEmit: begin
        if (sts_i.out_free) state_d = trs_pkg::StIdle;
      end
      default: state_d = trs_pkg::StIdle;
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    case (state_q)
      trs_pkg::StIdle: begin
        in_ready_o     = 1'b1;
        cmd_o.load_req = in_valid_i;
      end
      trs_pkg::StStart: begin
        cmd_o.start = 1'b1;
      end
      trs_pkg::StCheck: ;
      trs_pkg::StEval: begin
        cmd_o.eval = 1'b1;
      end
      trs_pkg::StEmit: begin
        cmd_o.emit = sts_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

[sv/trs_dpath.sv]
// ----------------------------------------------------------------------------
// trs_dpath
// Store state, header memory, request and result registers, output stage.
// Each record header is kept as one {tag, length} word at its start offset.
// ----------------------------------------------------------------------------
module trs_dpath #(
  parameter int unsigned BufSize = trs_pkg::BufSizeDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  trs_pkg::trs_cmd_t             cmd_i,
  output trs_pkg::trs_sts_t             sts_o,
  input  logic [trs_pkg::KindW-1:0]     in_kind_i,
  input  logic [trs_pkg::InDataW-1:0]   in_data_i,
  input  logic                          cfg_we_i,
  input  logic [trs_pkg::CapW-1:0]      cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [trs_pkg::OutDataW-1:0]  out_data_o,
  output logic                          out_found_o
);

  localparam int unsigned AW = $clog2(BufSize);
  localparam logic [trs_pkg::CapW-1:0] CapClamp =
    (BufSize > 2047) ? 11'd2047 : trs_pkg::CapW'(BufSize);

  logic [trs_pkg::KindW-1:0]   req_kind_q, req_kind_d;
  logic [trs_pkg::SizeW-1:0]   req_size_q, req_size_d;
  logic [trs_pkg::TagW-1:0]    req_tag_q, req_tag_d;
  logic [trs_pkg::NthW-1:0]    req_nth_q, req_nth_d;
  logic [trs_pkg::CapW-1:0]    cap_q, cap_d;
  logic [trs_pkg::CapW-1:0]    fill_end_q, fill_end_d;
  logic [trs_pkg::CapW-1:0]    cursor_q, cursor_d;
  logic [trs_pkg::CountW-1:0]  count_q, count_d;
  logic [trs_pkg::PosW-1:0]    pos_q, pos_d;
  logic [trs_pkg::CountW-1:0]  cnt_q, cnt_d;
  logic                        res_found_q, res_found_d;
  logic [trs_pkg::OffW-1:0]    res_off_q, res_off_d;
  logic [trs_pkg::TagW-1:0]    res_type_q, res_type_d;
  logic                        out_valid_q, out_valid_d;
  logic [trs_pkg::OutDataW-1:0] out_data_q, out_data_d;
  logic                        out_found_q, out_found_d;

  logic [15:0]                 hdr_mem [BufSize];
  logic [15:0]                 rd_q;
  logic                        mem_we;
  logic [AW+trs_pkg::PosW-1:0] pos_wide;
  logic [AW+trs_pkg::PosW-1:0] fill_wide;

  logic [trs_pkg::CapW-1:0]    cap_eff;
  logic [trs_pkg::CapW-1:0]    free_bytes;
  logic [trs_pkg::PosW-1:0]    new_end;
  logic                        add_ok;
  logic [trs_pkg::CapW-1:0]    add_off;
  logic [trs_pkg::PosW-1:0]    pos_off;
  logic [trs_pkg::SizeW-1:0]   rd_len;
  logic [trs_pkg::TagW-1:0]    rd_tag;
  logic [trs_pkg::PosW-1:0]    nxt;
  logic [trs_pkg::CapW-1:0]    nxt_clip;
  logic                        tag_match;
  logic                        nth_hit;
  trs_pkg::trs_kind_e          kind;

  assign kind      = trs_pkg::trs_kind_e'(req_kind_q);
  assign pos_wide  = {{AW{1'b0}}, pos_q};
  assign fill_wide = {{(AW + 1){1'b0}}, fill_end_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) hdr_mem[fill_wide[AW-1:0]] <= {req_tag_q, req_size_q + 8'(trs_pkg::HdrBytes)};
    rd_q <= hdr_mem[pos_wide[AW-1:0]];
  end

  assign rd_tag = rd_q[15:8];
  assign rd_len = (rd_q[7:0] < 8'(trs_pkg::HdrBytes)) ? 8'(trs_pkg::HdrBytes) : rd_q[7:0];

  assign cap_eff    = (cap_q > CapClamp) ? CapClamp : cap_q;
  assign free_bytes = (cap_eff > fill_end_q) ? (cap_eff - fill_end_q) : '0;
  assign new_end    = {1'b0, fill_end_q} + {4'b0, req_size_q} + 12'(trs_pkg::HdrBytes);
  assign add_ok     = (req_size_q <= trs_pkg::MaxPayload) && (new_end < {1'b0, cap_eff});
  assign add_off    = fill_end_q + 11'(trs_pkg::HdrBytes);
  assign pos_off    = pos_q + 12'(trs_pkg::HdrBytes);
  assign nxt        = pos_q + {4'b0, rd_len};
  assign nxt_clip   = (nxt > {1'b0, fill_end_q}) ? fill_end_q : nxt[trs_pkg::CapW-1:0];
  assign tag_match  = (req_tag_q == trs_pkg::TagAny) || (req_tag_q == rd_tag);
  assign nth_hit    = tag_match && (cnt_q == {1'b0, req_nth_q});

  always_comb begin
    sts_o.search   = kind inside {trs_pkg::KindPeek, trs_pkg::KindNext, trs_pkg::KindNth};
    sts_o.more     = pos_q < {1'b0, fill_end_q};
    sts_o.out_free = !out_valid_q || out_ready_i;
    case (kind)
      trs_pkg::KindPeek: sts_o.hit = 1'b1;
      trs_pkg::KindNext: sts_o.hit = tag_match;
      trs_pkg::KindNth:  sts_o.hit = nth_hit;
      default:           sts_o.hit = 1'b0;
    endcase
  end

  always_comb begin
    req_kind_d  = req_kind_q;
    req_size_d  = req_size_q;
    req_tag_d   = req_tag_q;
    req_nth_d   = req_nth_q;
    cap_d       = cap_q;
    fill_end_d  = fill_end_q;
    cursor_d    = cursor_q;
    count_d     = count_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    res_found_d = res_found_q;
    res_off_d   = res_off_q;
    res_type_d  = res_type_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_found_d = out_found_q;
    mem_we      = 1'b0;

    if (cmd_i.load_req) begin
      req_kind_d = in_kind_i;
      req_size_d = in_data_i[7:0];
      req_tag_d  = in_data_i[15:8];
      req_nth_d  = in_data_i[24:16];
    end

    if (cfg_we_i) cap_d = cfg_data_i;

    if (cmd_i.start) begin
      res_found_d = 1'b0;
      res_off_d   = '0;
      res_type_d  = trs_pkg::TagAny;
      case (kind)
        trs_pkg::KindAdd: begin
          if (add_ok) begin
            mem_we      = 1'b1;
            fill_end_d  = new_end[trs_pkg::CapW-1:0];
            if (count_q != trs_pkg::CountMax) count_d = count_q + 10'd1;
            res_found_d = 1'b1;
            res_off_d   = add_off[trs_pkg::OffW-1:0];
            res_type_d  = req_tag_q;
          end
        end
        trs_pkg::KindWipe: begin
          fill_end_d = '0;
          cursor_d   = '0;
          count_d    = '0;
        end
        trs_pkg::KindRewind: cursor_d = '0;
        trs_pkg::KindPeek, trs_pkg::KindNext: pos_d = {1'b0, cursor_q};
        trs_pkg::KindNth: begin
          pos_d = '0;
          cnt_d = '0;
        end
        default: ;
      endcase
    end

    if (cmd_i.eval) begin
      case (kind)
        trs_pkg::KindPeek: begin
          res_found_d = 1'b1;
          res_off_d   = pos_off[trs_pkg::OffW-1:0];
          res_type_d  = rd_tag;
        end
        trs_pkg::KindNext: begin
          pos_d    = nxt;
          cursor_d = nxt_clip;
          if (tag_match) begin
            res_found_d = 1'b1;
            res_off_d   = pos_off[trs_pkg::OffW-1:0];
            res_type_d  = rd_tag;
          end
        end
        trs_pkg::KindNth: begin
          if (nth_hit) begin
            res_found_d = 1'b1;
            res_off_d   = pos_off[trs_pkg::OffW-1:0];
            res_type_d  = rd_tag;
          end else begin
            if (tag_match) cnt_d = cnt_q + 10'd1;
            pos_d = nxt;
          end
        end
        default: ;
      endcase
    end

    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_found_d = res_found_q;
      out_data_d  = {6'b0, count_q, fill_end_q, free_bytes, res_type_q, res_off_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= trs_pkg::CapReset;
      fill_end_q  <= '0;
      cursor_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cap_q       <= cap_d;
      fill_end_q  <= fill_end_d;
      cursor_q    <= cursor_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_kind_q  <= req_kind_d;
    req_size_q  <= req_size_d;
    req_tag_q   <= req_tag_d;
    req_nth_q   <= req_nth_d;
    pos_q       <= pos_d;
    cnt_q       <= cnt_d;
    res_found_q <= res_found_d;
    res_off_q   <= res_off_d;
    res_type_q  <= res_type_d;
    out_data_q  <= out_data_d;
    out_found_q <= out_found_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_found_o = out_found_q;

endmodule

[sv/tagged_record_store_unit.sv]
// ----------------------------------------------------------------------------
// tagged_record_store_unit
// Bump-allocated store of tagged record headers with add, wipe, rewind,
// peek, next-match and nth-match requests; one result beat per request.
//
//   channel   dir  beat contents
//   s_axis    in   tuser: kind[2:0]; tdata: payload_size, type_tag, match_index
//   m_axis    out  tuser: found[0]; tdata: offset, type, free, used, count
//   cfg       in   capacity[10:0]
//
// add, wipe, rewind and unused kinds: update in the start state, then emit
// peek: check, eval, emit, or check, emit at the fill end; next and nth match:
// check and eval per header to a hit or the fill end, one registered read per hop
// after reset the store is empty and capacity is 1024; no clearing pass
// a new request is taken while the previous result waits in the output
// register; the next result waits until that register is free
// ----------------------------------------------------------------------------
module tagged_record_store_unit #(
  parameter int unsigned BufSize = trs_pkg::BufSizeDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // payload_size[7:0], type_tag[15:8], match_index[24:16]
  input  logic [trs_pkg::InDataW-1:0]   s_axis_tdata,
  // kind[2:0]
  input  logic [trs_pkg::KindW-1:0]     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // payload_offset[9:0], type_out[17:10], free_bytes[28:18],
  // used_bytes[39:29], record_count[49:40]
  output logic [trs_pkg::OutDataW-1:0]  m_axis_tdata,
  // found[0]
  output logic                          m_axis_tuser,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [trs_pkg::CapW-1:0]      cfg_data_i
);

  trs_pkg::trs_cmd_t cmd;
  trs_pkg::trs_sts_t sts;

  assign cfg_ready_o = 1'b1;

  trs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  trs_dpath #(
    .BufSize (BufSize)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_kind_i   (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_found_o (m_axis_tuser)
  );

endmodule
